>>> hw/rtl/dsk_rw_pkg.sv
// Shared types and constants of the disk read/write bit logic.
package dsk_rw_pkg;

  localparam logic [9:0] SYNC_ONES   = 10'h3FF;
  localparam logic [1:0] PHASE_SHIFT = 2'd2;
  localparam logic [1:0] PHASE_LOAD  = 2'd3;
  localparam logic [2:0] BIT_FULL    = 3'd7;

  typedef struct packed {
    logic [3:0] phase_counter;
    logic [1:0] cell_counter;
    logic [9:0] read_shift;
    logic [7:0] write_shift;
    logic [2:0] bit_counter;
    logic       sync_level;
    logic       ready_level;
  } rw_state_t;

  typedef struct packed {
    logic       kind;
    logic       motor_on;
    logic       write_mode;
    logic       head_bit;
    logic       light_barrier;
    logic       byte_ready_enable;
    logic [7:0] port_value;
  } rw_item_t;

  typedef struct packed {
    logic       byte_ready;
    logic       byte_ready_changed;
    logic       sync_inactive;
    logic [7:0] read_byte;
    logic       head_write_strobe;
    logic       head_write_bit;
    logic       advance_disk;
  } rw_result_t;

endpackage

>>> hw/rtl/dsk_rw_step.sv
// Next-state and result logic for one event of the read/write bit logic.
module dsk_rw_step
  import dsk_rw_pkg::*;
(
  input  rw_state_t  st,
  input  rw_item_t   item,
  output rw_state_t  st_next,
  output rw_result_t res
);

  always_comb begin
    rw_state_t  s;
    logic       changed;
    logic       strobe;
    logic       wbit;
    logic       advance;
    logic       level;

    s       = st;
    changed = 1'b0;
    strobe  = 1'b0;
    wbit    = 1'b0;
    advance = 1'b0;
    level   = 1'b1;

    if (!item.kind) begin
      // Byte ready is pulled low only with the enable set, phase bit one
      // clear and a full byte counted.
      level = !(item.byte_ready_enable && !s.phase_counter[1] &&
                (s.bit_counter == BIT_FULL));
      changed       = (s.ready_level != level);
      s.ready_level = level;
    end else if (item.motor_on) begin
      s.phase_counter = s.phase_counter + 4'd1;
      s.cell_counter  = s.cell_counter + 2'd1;
      if (s.cell_counter == 2'd0) begin
        if (!item.write_mode && item.head_bit) begin
          s.phase_counter = 4'd0;
        end
        advance = 1'b1;
      end
      s.sync_level = (s.read_shift != SYNC_ONES) || item.write_mode;
      if (!s.sync_level) begin
        s.bit_counter = 3'd0;
      end
      case (s.phase_counter[1:0])
        PHASE_SHIFT: begin
          changed       = !s.ready_level;
          s.ready_level = 1'b1;
          s.bit_counter = s.sync_level ? s.bit_counter + 3'd1 : 3'd0;
          if (item.write_mode && !item.light_barrier) begin
            strobe = 1'b1;
            wbit   = s.write_shift[7];
          end
          s.write_shift = {s.write_shift[6:0], 1'b0};
          s.read_shift  = {s.read_shift[8:0], (s.phase_counter[3:2] == 2'd0)};
        end
        PHASE_LOAD: begin
          if (s.bit_counter == BIT_FULL) begin
            s.write_shift = item.port_value;
          end
        end
        default: begin
          level = !(item.byte_ready_enable && !s.phase_counter[1] &&
                    (s.bit_counter == BIT_FULL));
          changed       = (s.ready_level != level);
          s.ready_level = level;
        end
      endcase
    end

    st_next                = s;
    res.byte_ready         = s.ready_level;
    res.byte_ready_changed = changed;
    res.sync_inactive      = s.sync_level;
    res.read_byte          = s.read_shift[7:0];
    res.head_write_strobe  = strobe;
    res.head_write_bit     = wbit;
    res.advance_disk       = advance;
  end

endmodule

>>> hw/rtl/disk_read_write_bit_logic.sv
// Top level of the disk read/write bit logic: input register, state and result register.
//
// The block takes one event request per cycle, while in_stall is low, on the input
// channel: either a cpu tick (kind = 0), which only re-evaluates the byte-ready line,
// or a carry pulse of the bit-cell clock (kind = 1), which with the motor on advances
// the phase and cell counters, samples the head, shifts the read and write registers
// and sequences byte ready. Every request yields exactly one result request.
//
// A request is taken when in_valid is high and in_stall is low. It lands in
// an input register; the step logic then computes the new drive state and
// the result, which are written together into the state registers and the
// output register once that is empty or being drained. Throughput is one
// request per cycle while the receiver does not stall, set by the single
// pass through the step logic between the two registers.
//
// When the receiver raises out_stall, the result holds steady; the input
// register still accepts one more request, after which in_stall rises until
// the result is taken. Synchronous reset clears all drive state to zero
// (the stored byte-ready and sync levels low until the first event) and
// empties both registers.
module disk_read_write_bit_logic
  import dsk_rw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic       motor_on,
  input  logic       write_mode,
  input  logic       head_bit,
  input  logic       light_barrier,
  input  logic       byte_ready_enable,
  input  logic [7:0] port_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       byte_ready,
  output logic       byte_ready_changed,
  output logic       sync_inactive,
  output logic [7:0] read_byte,
  output logic       head_write_strobe,
  output logic       head_write_bit,
  output logic       advance_disk
);

  rw_state_t  state;
  rw_state_t  state_next;
  rw_item_t   held;
  logic       held_valid;
  rw_result_t result;
  rw_result_t result_next;
  logic       load_out;
  logic       take_in;

  // The output register loads whenever the input register holds a request and it is empty or being drained.
  assign load_out = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && !load_out;
  assign take_in  = in_valid && !in_stall;

  dsk_rw_step u_step (
    .st      (state),
    .item    (held),
    .st_next (state_next),
    .res     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
      state      <= '0;
    end else begin
      if (take_in) begin
        held_valid <= 1'b1;
      end else if (load_out) begin
        held_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (take_in) begin
      held <= '{kind: kind, motor_on: motor_on, write_mode: write_mode,
                head_bit: head_bit, light_barrier: light_barrier,
                byte_ready_enable: byte_ready_enable, port_value: port_value};
    end
    if (load_out) begin
      result <= result_next;
    end
  end

  assign byte_ready         = result.byte_ready;
  assign byte_ready_changed = result.byte_ready_changed;
  assign sync_inactive      = result.sync_inactive;
  assign read_byte          = result.read_byte;
  assign head_write_strobe  = result.head_write_strobe;
  assign head_write_bit     = result.head_write_bit;
  assign advance_disk       = result.advance_disk;

endmodule

>>> hw/rtl/dsk_rw_checker.sv
// Port-level assertions for the disk read/write bit logic, bound to the top level.
module dsk_rw_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       byte_ready,
  input logic       byte_ready_changed,
  input logic [7:0] read_byte,
  input logic       head_write_strobe,
  input logic       head_write_bit
);

  // A written bit is only ever reported together with its strobe.
  a_wbit_needs_strobe: assert property (@(posedge clk) disable iff (rst)
    out_valid && head_write_bit |-> head_write_strobe)
    else $error("head_write_bit set without head_write_strobe");

  // A head write happens in the shift phase, which forces byte ready high.
  a_strobe_ready_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && head_write_strobe |-> byte_ready)
    else $error("head write with byte ready low");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_byte) &&
    $stable(byte_ready) && $stable(byte_ready_changed))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind disk_read_write_bit_logic dsk_rw_checker u_dsk_rw_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .byte_ready         (byte_ready),
  .byte_ready_changed (byte_ready_changed),
  .read_byte          (read_byte),
  .head_write_strobe  (head_write_strobe),
  .head_write_bit     (head_write_bit)
);
